// File: rtl/ipid_pkg.sv
// ---------------------------------------------------------------------------
// ipid_pkg: shared types and constants of the incremental PID controller
// Field widths, arithmetic widths, register indexes and payload structs.
// ---------------------------------------------------------------------------
package ipid_pkg;

  localparam int MOTORS         = 4;
  localparam int GAIN_FRAC_BITS = 12;

  localparam int MOTOR_W   = 2;
  localparam int DATA_W    = 16;
  localparam int ERR_W     = DATA_W + 1;
  localparam int D1_W      = ERR_W + 1;
  localparam int D2_W      = ERR_W + 2;
  localparam int P0_W      = DATA_W + ERR_W;
  localparam int P1_W      = DATA_W + D1_W;
  localparam int P2_W      = DATA_W + D2_W;
  localparam int ACC_W     = P2_W + 2;
  localparam int SUM_W     = ACC_W + 1;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_PROP  = 3'd0,
    REG_GAIN_DIFF1 = 3'd1,
    REG_GAIN_DIFF2 = 3'd2,
    REG_DRIVE_MIN  = 3'd3,
    REG_DRIVE_MAX  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic        [MOTOR_W-1:0] motor_sel;
    logic signed [DATA_W-1:0]  target;
    logic signed [DATA_W-1:0]  encoder;
  } in_item_t;

  typedef struct packed {
    logic        [MOTOR_W-1:0] motor_out;
    logic signed [DATA_W-1:0]  drive;
    logic                      clamped;
  } out_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] gain_prop;
    logic signed [DATA_W-1:0] gain_diff1;
    logic signed [DATA_W-1:0] gain_diff2;
  } gains_t;

endpackage

// File: rtl/ipid_mult.sv
// ---------------------------------------------------------------------------
// ipid_mult: registered gain multiplier stage
// Multiplies the error, its first and its second difference by their gains.
// ---------------------------------------------------------------------------
module ipid_mult (
  input  logic                                clk,
  input  logic                                load,
  input  ipid_pkg::gains_t                    gains,
  input  logic signed [ipid_pkg::ERR_W-1:0]   e0,
  input  logic signed [ipid_pkg::D1_W-1:0]    d1,
  input  logic signed [ipid_pkg::D2_W-1:0]    d2,
  output logic signed [ipid_pkg::P0_W-1:0]    p0_r,
  output logic signed [ipid_pkg::P1_W-1:0]    p1_r,
  output logic signed [ipid_pkg::P2_W-1:0]    p2_r
);

  logic signed [ipid_pkg::P0_W-1:0] p0_nxt;
  logic signed [ipid_pkg::P1_W-1:0] p1_nxt;
  logic signed [ipid_pkg::P2_W-1:0] p2_nxt;

  // Three independent 16-by-19-bit (or narrower) products.
  assign p0_nxt = gains.gain_prop  * e0;
  assign p1_nxt = gains.gain_diff1 * d1;
  assign p2_nxt = gains.gain_diff2 * d2;

  always_ff @(posedge clk) begin
    if (load) begin
      p0_r <= p0_nxt;
      p1_r <= p1_nxt;
      p2_r <= p2_nxt;
    end
  end

endmodule

// File: rtl/incremental_pid_motor_control.sv
// ---------------------------------------------------------------------------
// incremental_pid_motor_control: velocity-form PID drive for a motor bank
// Per-motor incremental PID with clamped drive output and valid/ready ports.
// ---------------------------------------------------------------------------
// Each input transfer names a motor and carries its target and encoder
// reading; each produces exactly one output transfer with that motor's new
// drive value, clamped to [drive_min, drive_max], and a flag that tells
// whether the clamp acted. The block is a three-register pipeline: an input
// register where the error and its differences are formed, a product
// register fed by three parallel gain multipliers, and a result register
// after the accumulate, shift, add and clamp. It sustains one transfer per
// clock cycle while the output side does not stall. A sample passes
// through the input, product and result registers in turn, and out_valid
// rises once it is in the result register. The per-motor error history is
// updated when an item leaves the input register and the stored drive value
// when it leaves the product register, so back-to-back samples for the same
// motor always see the state left by the one before. Gains and limits are
// written through the cfg_ port and should be changed only while no sample
// is in flight. Indexes above the last register are ignored. If drive_min is
// above drive_max, a sum above drive_max yields it, any other drive_min.
// ---------------------------------------------------------------------------
module incremental_pid_motor_control (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Input channel
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  ipid_pkg::in_item_t                    in_data,
  // Result channel
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output ipid_pkg::out_item_t                   out_data,
  // Configuration write port
  input  logic                                  cfg_we,
  input  logic [ipid_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ipid_pkg::DATA_W-1:0]           cfg_wdata
);

  // Configuration registers.
  ipid_pkg::gains_t                   gains_r;
  logic signed [ipid_pkg::DATA_W-1:0] drive_min_r;
  logic signed [ipid_pkg::DATA_W-1:0] drive_max_r;

  // Per-motor state.
  logic signed [ipid_pkg::ERR_W-1:0]  err_last_r   [ipid_pkg::MOTORS];
  logic signed [ipid_pkg::ERR_W-1:0]  err_prev_r   [ipid_pkg::MOTORS];
  logic signed [ipid_pkg::DATA_W-1:0] drive_last_r [ipid_pkg::MOTORS];

  // Pipeline registers.
  logic                               in_v_r;
  ipid_pkg::in_item_t                 in_r;
  logic                               prod_v_r;
  logic [ipid_pkg::MOTOR_W-1:0]       prod_sel_r;
  logic                               prod_rng_r;
  logic                               out_v_r;
  ipid_pkg::out_item_t                out_r;

  // Handshake between stages.
  logic out_load;
  logic prod_ready;
  logic prod_load;
  logic in_load;

  // Input stage datapath.
  logic                               in_rng;
  logic signed [ipid_pkg::ERR_W-1:0]  e0;
  logic signed [ipid_pkg::ERR_W-1:0]  e1;
  logic signed [ipid_pkg::ERR_W-1:0]  e2;
  logic signed [ipid_pkg::D1_W-1:0]   d1;
  logic signed [ipid_pkg::D2_W-1:0]   d2;

  // Product stage datapath.
  logic signed [ipid_pkg::P0_W-1:0]   p0_r;
  logic signed [ipid_pkg::P1_W-1:0]   p1_r;
  logic signed [ipid_pkg::P2_W-1:0]   p2_r;
  logic signed [ipid_pkg::ACC_W-1:0]  acc;
  logic signed [ipid_pkg::ACC_W-1:0]  inc;
  logic signed [ipid_pkg::SUM_W-1:0]  sum;
  logic signed [ipid_pkg::SUM_W-1:0]  lim_hi;
  logic signed [ipid_pkg::SUM_W-1:0]  lim_lo;
  ipid_pkg::out_item_t                out_nxt;

  // A stage takes a new item when it is empty or its item moves on this cycle.
  assign out_load   = prod_v_r && (!out_v_r || out_ready);
  assign prod_ready = !prod_v_r || out_load;
  assign prod_load  = in_v_r && prod_ready;
  assign in_ready   = !in_v_r || prod_ready;
  assign in_load    = in_valid && in_ready;

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gains_r     <= '0;
      drive_min_r <= {1'b1, {(ipid_pkg::DATA_W-1){1'b0}}};
      drive_max_r <= {1'b0, {(ipid_pkg::DATA_W-1){1'b1}}};
    end else if (cfg_we) begin
      unique case (cfg_index)
        ipid_pkg::REG_GAIN_PROP:  gains_r.gain_prop  <= cfg_wdata;
        ipid_pkg::REG_GAIN_DIFF1: gains_r.gain_diff1 <= cfg_wdata;
        ipid_pkg::REG_GAIN_DIFF2: gains_r.gain_diff2 <= cfg_wdata;
        ipid_pkg::REG_DRIVE_MIN:  drive_min_r        <= cfg_wdata;
        ipid_pkg::REG_DRIVE_MAX:  drive_max_r        <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input stage: error and its first and second differences. A motor index
  // beyond the bank leaves all state alone and yields a zero drive.
  assign in_rng = (int'(in_r.motor_sel) < ipid_pkg::MOTORS);
  assign e0 = ipid_pkg::ERR_W'(in_r.target) - ipid_pkg::ERR_W'(in_r.encoder);
  assign e1 = in_rng ? err_last_r[in_r.motor_sel] : '0;
  assign e2 = in_rng ? err_prev_r[in_r.motor_sel] : '0;
  assign d1 = ipid_pkg::D1_W'(e0) - ipid_pkg::D1_W'(e1);
  assign d2 = ipid_pkg::D2_W'(e0) - (ipid_pkg::D2_W'(e1) <<< 1) + ipid_pkg::D2_W'(e2);

  ipid_mult u_mult (
    .clk   (clk),
    .load  (prod_load),
    .gains (gains_r),
    .e0    (e0),
    .d1    (d1),
    .d2    (d2),
    .p0_r  (p0_r),
    .p1_r  (p1_r),
    .p2_r  (p2_r)
  );

  // Product stage: accumulate, drop the fraction bits rounding toward minus
  // infinity, add to the last drive and clamp with the upper limit first.
  assign acc    = ipid_pkg::ACC_W'(p0_r) + ipid_pkg::ACC_W'(p1_r) + ipid_pkg::ACC_W'(p2_r);
  assign inc    = acc >>> ipid_pkg::GAIN_FRAC_BITS;
  assign lim_hi = ipid_pkg::SUM_W'(drive_max_r);
  assign lim_lo = ipid_pkg::SUM_W'(drive_min_r);

  always_comb begin
    sum = ipid_pkg::SUM_W'(inc);
    out_nxt.motor_out = prod_sel_r;
    out_nxt.drive     = '0;
    out_nxt.clamped   = 1'b0;
    if (prod_rng_r) begin
      sum = ipid_pkg::SUM_W'(inc) + ipid_pkg::SUM_W'(drive_last_r[prod_sel_r]);
      priority if (sum > lim_hi) begin
        out_nxt.drive   = drive_max_r;
        out_nxt.clamped = 1'b1;
      end else if (sum < lim_lo) begin
        out_nxt.drive   = drive_min_r;
        out_nxt.clamped = 1'b1;
      end else begin
        out_nxt.drive   = sum[ipid_pkg::DATA_W-1:0];
      end
    end
  end

  // Per-motor state updates.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ipid_pkg::MOTORS; i++) begin
        err_last_r[i]   <= '0;
        err_prev_r[i]   <= '0;
        drive_last_r[i] <= '0;
      end
    end else begin
      if (prod_load && in_rng) begin
        err_prev_r[in_r.motor_sel] <= e1;
        err_last_r[in_r.motor_sel] <= e0;
      end
      if (out_load && prod_rng_r) begin
        drive_last_r[prod_sel_r] <= out_nxt.drive;
      end
    end
  end

  // Stage valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r   <= 1'b0;
      prod_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (in_load) begin
        in_v_r <= 1'b1;
      end else if (prod_load) begin
        in_v_r <= 1'b0;
      end
      if (prod_load) begin
        prod_v_r <= 1'b1;
      end else if (out_load) begin
        prod_v_r <= 1'b0;
      end
      if (out_load) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (in_load) begin
      in_r <= in_data;
    end
    if (prod_load) begin
      prod_sel_r <= in_r.motor_sel;
      prod_rng_r <= in_rng;
    end
    if (out_load) begin
      out_r <= out_nxt;
    end
  end

endmodule

// File: rtl/ipid_checker.sv
// ---------------------------------------------------------------------------
// ipid_checker: port-level checks for the incremental PID controller
// Watches the handshake ports of the top level and is bound to it below.
// ---------------------------------------------------------------------------
module ipid_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input ipid_pkg::out_item_t out_data
);

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // The input side only backs up when the result side is stalled.
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled while result side is free");

  // A pending result is held until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped before transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(out_data))
    else $error("result changed before transfer");

endmodule

bind incremental_pid_motor_control ipid_checker u_ipid_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// File: verif/ipid_drive_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// ipid_drive_checker: result predictor and scoreboard for the PID drive block
// Watches the configuration port and both channels, predicts every drive
// value from its own per-motor state and compares each result transfer.
// ---------------------------------------------------------------------------
module ipid_drive_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  ipid_pkg::in_item_t             in_data,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  ipid_pkg::out_item_t            out_data,
  input  logic                           cfg_we,
  input  logic [ipid_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ipid_pkg::DATA_W-1:0]    cfg_wdata,
  output int                             fault_count,
  output int                             drives_in_flight
);

  logic signed [ipid_pkg::DATA_W-1:0] gain_p, gain_d1, gain_d2, drive_lo, drive_hi;
  logic signed [ipid_pkg::ERR_W-1:0]  err_prev   [ipid_pkg::MOTORS];
  logic signed [ipid_pkg::ERR_W-1:0]  err_prev2  [ipid_pkg::MOTORS];
  logic signed [ipid_pkg::DATA_W-1:0] drive_prev [ipid_pkg::MOTORS];
  ipid_pkg::out_item_t                expected_drives [$];
  int                                 faults = 0;

  // Advances one motor's history and returns the drive value it yields.
  function automatic ipid_pkg::out_item_t next_drive(ipid_pkg::in_item_t s);
    ipid_pkg::out_item_t r;
    longint              e0, e1, e2, inc, sum;
    int                  m;
    m           = s.motor_sel;
    r.motor_out = s.motor_sel;
    r.drive     = '0;
    r.clamped   = 1'b0;
    if (m >= ipid_pkg::MOTORS) return r;
    e0  = longint'(s.target) - longint'(s.encoder);
    e1  = longint'(err_prev[m]);
    e2  = longint'(err_prev2[m]);
    inc = longint'(gain_p) * e0 + longint'(gain_d1) * (e0 - e1)
        + longint'(gain_d2) * (e0 - 2 * e1 + e2);
    sum = longint'(drive_prev[m]) + (inc >>> ipid_pkg::GAIN_FRAC_BITS);
    if (sum > longint'(drive_hi)) begin
      sum       = longint'(drive_hi);
      r.clamped = 1'b1;
    end else if (sum < longint'(drive_lo)) begin
      sum       = longint'(drive_lo);
      r.clamped = 1'b1;
    end
    err_prev2[m]  = err_prev[m];
    err_prev[m]   = e0[ipid_pkg::ERR_W-1:0];
    drive_prev[m] = sum[ipid_pkg::DATA_W-1:0];
    r.drive       = sum[ipid_pkg::DATA_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    ipid_pkg::out_item_t want;
    if (!rst_n) begin
      gain_p   = '0;
      gain_d1  = '0;
      gain_d2  = '0;
      drive_lo = 16'sh8000;
      drive_hi = 16'sh7fff;
      for (int i = 0; i < ipid_pkg::MOTORS; i++) begin
        err_prev[i]   = '0;
        err_prev2[i]  = '0;
        drive_prev[i] = '0;
      end
      expected_drives.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          ipid_pkg::REG_GAIN_PROP:  gain_p   = $signed(cfg_wdata);
          ipid_pkg::REG_GAIN_DIFF1: gain_d1  = $signed(cfg_wdata);
          ipid_pkg::REG_GAIN_DIFF2: gain_d2  = $signed(cfg_wdata);
          ipid_pkg::REG_DRIVE_MIN:  drive_lo = $signed(cfg_wdata);
          ipid_pkg::REG_DRIVE_MAX:  drive_hi = $signed(cfg_wdata);
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_drives.size() == 0) begin
          $error("unexpected result transfer: motor_out %0d, drive %0d, clamped %0b",
                 out_data.motor_out, out_data.drive, out_data.clamped);
          faults++;
        end else begin
          want = expected_drives.pop_front();
          if (out_data.motor_out !== want.motor_out) begin
            $error("motor_out: expected %0d, got %0d", want.motor_out, out_data.motor_out);
            faults++;
          end
          if (out_data.drive !== want.drive) begin
            $error("drive: expected %0d, got %0d", want.drive, out_data.drive);
            faults++;
          end
          if (out_data.clamped !== want.clamped) begin
            $error("clamped: expected %0b, got %0b", want.clamped, out_data.clamped);
            faults++;
          end
        end
      end
      if (in_valid && in_ready) expected_drives.push_back(next_drive(in_data));
    end
    drives_in_flight <= expected_drives.size();
    fault_count      <= faults;
  end

endmodule

// File: verif/tb_incremental_pid_motor_control.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_incremental_pid_motor_control: testbench for the incremental PID drive
// Drives directed and random motor samples through several gain and limit
// settings with random idling on both channels; a checker module predicts
// and compares every result, and this top gives the verdict.
// ---------------------------------------------------------------------------
module tb_incremental_pid_motor_control;

  // An index past the last register; writes to it must leave the block alone.
  localparam logic [ipid_pkg::CFG_IDX_W-1:0] REG_NONE = 3'd7;
  // The pipeline is three stages deep; this many idle cycles cover it.
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_ITEMS   = 104;

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_ready;
  ipid_pkg::in_item_t             in_data;
  logic                           out_valid;
  logic                           out_ready;
  ipid_pkg::out_item_t            out_data;
  logic                           cfg_we;
  logic [ipid_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [ipid_pkg::DATA_W-1:0]    cfg_wdata;
  int                             fault_count;
  int                             drives_in_flight;
  // When set, both sides run without gaps so back-to-back transfers occur.
  bit                             no_gaps;

  incremental_pid_motor_control dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  ipid_drive_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data          (in_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_data         (out_data),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .fault_count      (fault_count),
    .drives_in_flight (drives_in_flight)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The run is far shorter than this even with every gap at its longest.
  initial begin
    #3_000_000;
    $display("tb_incremental_pid_motor_control: done, errors");
    $finish;
  end

  // Result side: before every transfer the receiver holds ready low for a
  // random gap, or none, then keeps ready high until a result is taken. Ready is
  // only lowered when a gap is drawn, so it never gets two updates in one step.
  initial begin
    int gap;
    out_ready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      gap = no_gaps ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Presents one sample after a random gap and holds it until the transfer.
  // Valid stays high on return so the next sample can follow with no bubble.
  task automatic send_sample(input logic [ipid_pkg::MOTOR_W-1:0] motor,
                             input logic signed [ipid_pkg::DATA_W-1:0] tgt,
                             input logic signed [ipid_pkg::DATA_W-1:0] enc);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{motor_sel: motor, target: tgt, encoder: enc};
    do @(posedge clk); while (!in_ready);
  endtask

  // Stops the sender and waits until every predicted drive value has come
  // back, then lets the pipeline run empty. The first edge lets the count
  // in the checker take in the transfer accepted just before.
  task automatic drain_pipeline;
    in_valid <= 1'b0;
    @(posedge clk);
    while (drives_in_flight != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register writes are issued back to back; the enable is dropped once at
  // the end so it never sees two updates in the same step.
  task automatic cfg_put(input logic [ipid_pkg::CFG_IDX_W-1:0] idx,
                         input logic [ipid_pkg::DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  task automatic load_settings(input logic signed [ipid_pkg::DATA_W-1:0] kp,
                               input logic signed [ipid_pkg::DATA_W-1:0] kd1,
                               input logic signed [ipid_pkg::DATA_W-1:0] kd2,
                               input logic signed [ipid_pkg::DATA_W-1:0] lo,
                               input logic signed [ipid_pkg::DATA_W-1:0] hi);
    cfg_put(ipid_pkg::REG_GAIN_PROP, kp);
    cfg_put(ipid_pkg::REG_GAIN_DIFF1, kd1);
    cfg_put(ipid_pkg::REG_GAIN_DIFF2, kd2);
    cfg_put(ipid_pkg::REG_DRIVE_MIN, lo);
    cfg_put(ipid_pkg::REG_DRIVE_MAX, hi);
    // A write to an unused index carries random data and must change nothing.
    cfg_put(REG_NONE, 16'($urandom));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Uniform signed value in [-span, span].
  function automatic logic signed [ipid_pkg::DATA_W-1:0] rand_span(input int span);
    int v;
    v = int'($urandom_range(0, 2 * span)) - span;
    return v[ipid_pkg::DATA_W-1:0];
  endfunction

  function automatic logic signed [ipid_pkg::DATA_W-1:0] rand_extreme();
    return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
  endfunction

  initial begin
    logic signed [ipid_pkg::DATA_W-1:0] tgt;
    logic signed [ipid_pkg::DATA_W-1:0] lo;
    logic signed [ipid_pkg::DATA_W-1:0] hi;
    bit                                 near_target;

    no_gaps   = 1'b0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // With the reset gains every increment is zero, so drives stay at zero
    // even for the largest errors.
    send_sample(2'd0, 16'sh7fff, 16'sh8000);
    send_sample(2'd1, 16'sh8000, 16'sh7fff);
    send_sample(2'd3, 16'sh0000, 16'sh0000);
    drain_pipeline();

    // Moderate gains with a negative second-difference gain; the same motor
    // is hit back to back so each sample must see the history just written.
    load_settings(16'sd4096, 16'sd2048, -16'sd1024, 16'sh8000, 16'sh7fff);
    send_sample(2'd0, 16'sd100, 16'sd0);
    send_sample(2'd0, 16'sd0, 16'sd100);
    send_sample(2'd0, 16'sd0, 16'sd100);
    send_sample(2'd1, 16'sh7fff, 16'sh8000);
    send_sample(2'd1, 16'sh7fff, 16'sh8000);
    send_sample(2'd1, 16'sh8000, 16'sh7fff);
    send_sample(2'd2, -16'sd1, 16'sd0);
    send_sample(2'd3, 16'sd0, 16'sd0);
    drain_pipeline();

    // A tiny gain on a negative error checks that the shift rounds toward
    // minus infinity rather than toward zero.
    load_settings(16'sd1, 16'sd0, 16'sd0, -16'sd50, 16'sd50);
    send_sample(2'd2, -16'sd1, 16'sd0);
    send_sample(2'd2, 16'sd1, 16'sd0);
    send_sample(2'd2, -16'sd3, 16'sd0);
    drain_pipeline();

    // Crossed limits: the upper limit is tested first.
    load_settings(16'sd4096, 16'sd0, 16'sd0, 16'sd100, -16'sd100);
    send_sample(2'd3, 16'sd500, 16'sd0);
    send_sample(2'd3, -16'sd500, 16'sd0);
    send_sample(2'd3, 16'sd0, 16'sd0);
    drain_pipeline();

    // Most negative gains and full limits against the widest errors.
    load_settings(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff);
    send_sample(2'd0, 16'sh8000, 16'sh7fff);
    send_sample(2'd0, 16'sh7fff, 16'sh8000);
    send_sample(2'd1, 16'sh7fff, 16'sh8000);
    drain_pipeline();

    // Random phases. Each phase loads new settings while the block is idle,
    // and the drain at its end is where the sender waits for every result.
    for (int ph = 0; ph < 8; ph++) begin
      no_gaps = (ph == 2 || ph == 5);
      case (ph % 4)
        0: load_settings(16'($urandom), 16'($urandom), 16'($urandom),
                         16'sh8000, 16'sh7fff);
        1: begin
          lo = rand_span(2000);
          hi = rand_span(2000);
          load_settings(rand_span(4096), rand_span(4096), rand_span(4096), lo, hi);
        end
        2: load_settings(rand_extreme(), rand_extreme(), rand_extreme(),
                         16'($urandom), 16'($urandom));
        default: load_settings(rand_span(8192), rand_span(8192), rand_span(8192),
                               -16'sd30000, 16'sd30000);
      endcase
      // Phases with small gains mostly see small errors, as a settling loop
      // would, so the unclamped path and the history terms get exercised.
      near_target = (ph % 2) == 1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (near_target && $urandom_range(0, 9) != 0) begin
          tgt = rand_span(30000);
          send_sample(2'($urandom), tgt, tgt - rand_span(500));
        end else begin
          send_sample(2'($urandom), 16'($urandom), 16'($urandom));
        end
      end
      drain_pipeline();
    end

    if (fault_count == 0) begin
      $display("tb_incremental_pid_motor_control: done, clean");
    end else begin
      $display("tb_incremental_pid_motor_control: done, errors");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/ipid_pkg.sv
rtl/ipid_mult.sv
rtl/incremental_pid_motor_control.sv
rtl/ipid_checker.sv
verif/ipid_drive_checker.sv
verif/tb_incremental_pid_motor_control.sv
